@@ design/swts_pkg.sv @@
// package for the sorted word table search block
// holds widths, item codes, status codes and the controller state type
// no dependencies
package swts_pkg;

    localparam int MAX_WORD_LETTERS = 23;
    localparam int WORDS_PER_LENGTH = 1024;
    localparam int SPLIT_LETTERS    = 12;

    localparam int KIND_W   = 3;
    localparam int LEN_W    = 5;
    localparam int HIGH_W   = 60;
    localparam int LOW_W    = 55;
    localparam int KEY_W    = HIGH_W + LOW_W;
    localparam int POS_W    = $clog2(WORDS_PER_LENGTH);
    localparam int CNT_W    = POS_W + 1;
    localparam int STATUS_W = 3;
    localparam int TAB_W    = $clog2(MAX_WORD_LETTERS);
    localparam int ADDR_W   = TAB_W + POS_W;
    localparam int DEPTH    = MAX_WORD_LETTERS * WORDS_PER_LENGTH;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 3'd0,
        KIND_FIND  = 3'd1,
        KIND_LOWER = 3'd2,
        KIND_UPPER = 3'd3,
        KIND_FETCH = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_ABSENT = 3'd1,
        ST_FULL   = 3'd2,
        ST_ORDER  = 3'd3,
        ST_BADPOS = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD_CMP,
        S_PROBE,
        S_PROBE_CMP,
        S_CHECK,
        S_FETCH,
        S_DONE
    } state_t;

endpackage

@@ design/swts_if.sv @@
// channel interfaces for the sorted word table search block
// depends on swts_pkg
interface swts_req_if;
    logic                               valid;
    logic                               ready;
    logic [swts_pkg::KIND_W-1:0]        kind;
    logic [swts_pkg::LEN_W-1:0]         word_length;
    logic [swts_pkg::HIGH_W-1:0]        key_high;
    logic [swts_pkg::LOW_W-1:0]         key_low;
    logic [swts_pkg::POS_W-1:0]         position;

    modport source (output valid, kind, word_length, key_high, key_low, position,
                    input ready);
    modport sink   (input valid, kind, word_length, key_high, key_low, position,
                    output ready);
endinterface

interface swts_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [swts_pkg::STATUS_W-1:0]      status;
    logic [swts_pkg::CNT_W-1:0]         index;
    logic [swts_pkg::CNT_W-1:0]         entry_count;
    logic [swts_pkg::HIGH_W-1:0]        entry_high;
    logic [swts_pkg::LOW_W-1:0]         entry_low;

    modport source (output valid, status, index, entry_count, entry_high, entry_low,
                    input ready);
    modport sink   (input valid, status, index, entry_count, entry_high, entry_low,
                    output ready);
endinterface

@@ design/swts_key_ram.sv @@
// simple dual port key memory, one write port and one registered read port
// no dependencies
module swts_key_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sorted_word_table_search.sv @@
// top level of the sorted word table search block
// depends on swts_pkg, swts_req_if, swts_rsp_if and swts_key_ram
//
//   channel  dir   modport  payload
//   req      in    sink     kind, word_length, key_high, key_low, position
//   rsp      out   source   status, index, entry_count, entry_high, entry_low
//
// one item at a time; a search probe is a ram read plus a compare (S_PROBE, S_PROBE_CMP)
// find/lower/upper: up to 11 probes; find then checks the candidate entry in S_CHECK
// load/fetch read at most one key each; the output register lets the next item in early
// reset clears the per-length counts; the key ram needs no clearing
// a stalled rsp holds the finished result; a new item waits in S_DONE behind it
module sorted_word_table_search (
    input  logic        clk,
    input  logic        rst_n,
    swts_req_if.sink    req,
    swts_rsp_if.source  rsp
);

    localparam int KEY_W = swts_pkg::KEY_W;
    localparam int CNT_W = swts_pkg::CNT_W;
    localparam int POS_W = swts_pkg::POS_W;
    localparam int TAB_W = swts_pkg::TAB_W;

    swts_pkg::state_t state_reg, state_next;

    logic [swts_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic                          len_ok_reg, len_ok_next;
    logic [TAB_W-1:0]              tab_reg, tab_next;
    logic [swts_pkg::HIGH_W-1:0]   kh_reg, kh_next;
    logic [swts_pkg::LOW_W-1:0]    kl_reg, kl_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic [CNT_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;
    logic [CNT_W-1:0]              mid_reg, mid_next;

    logic [swts_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CNT_W-1:0]              res_index_reg, res_index_next;
    logic [CNT_W-1:0]              res_count_reg, res_count_next;
    logic [KEY_W-1:0]              res_entry_reg, res_entry_next;

    logic                          out_valid_reg;
    logic [swts_pkg::STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]              out_index_reg;
    logic [CNT_W-1:0]              out_count_reg;
    logic [KEY_W-1:0]              out_entry_reg;

    logic [CNT_W-1:0]              counts_reg [swts_pkg::MAX_WORD_LETTERS];

    logic                          ram_we, ram_re;
    logic [swts_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [KEY_W-1:0]              ram_rdata;
    logic                          cnt_we;

    logic                          accept, out_free, out_load;
    logic                          len_ok_in;
    logic [TAB_W-1:0]              tab_in;
    logic [KEY_W-1:0]              key;
    logic                          key_lt_entry, entry_lt_key, go_right;
    logic [CNT_W-1:0]              mid, n_m1;
    logic                          fin;
    logic [swts_pkg::STATUS_W-1:0] fin_status;
    logic [CNT_W-1:0]              fin_index, fin_count;
    logic [KEY_W-1:0]              fin_entry;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == swts_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = (state_reg == swts_pkg::S_DONE) && out_free;

    assign len_ok_in = (req.word_length != '0) &&
                       (req.word_length <= swts_pkg::LEN_W'(swts_pkg::MAX_WORD_LETTERS));
    assign tab_in    = TAB_W'(req.word_length - swts_pkg::LEN_W'(1));

    assign key          = {kh_reg, kl_reg};
    assign key_lt_entry = key < ram_rdata;
    assign entry_lt_key = ram_rdata < key;
    assign go_right     = (kind_reg == swts_pkg::KIND_UPPER) ? !key_lt_entry : entry_lt_key;
    assign mid          = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign n_m1         = n_reg - CNT_W'(1);
    assign ram_waddr    = {tab_reg, n_reg[POS_W-1:0]};

    swts_key_ram #(
        .DEPTH  (swts_pkg::DEPTH),
        .WIDTH  (KEY_W),
        .ADDR_W (swts_pkg::ADDR_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swts_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < swts_pkg::MAX_WORD_LETTERS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cnt_we)
            begin
                counts_reg[tab_reg] <= n_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        len_ok_reg      <= len_ok_next;
        tab_reg         <= tab_next;
        kh_reg          <= kh_next;
        kl_reg          <= kl_next;
        pos_reg         <= pos_next;
        n_reg           <= n_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        res_count_reg   <= res_count_next;
        res_entry_reg   <= res_entry_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_count_reg  <= res_count_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        len_ok_next     = len_ok_reg;
        tab_next        = tab_reg;
        kh_next         = kh_reg;
        kl_next         = kl_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_count_next  = res_count_reg;
        res_entry_next  = res_entry_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = {tab_reg, lo_reg[POS_W-1:0]};
        cnt_we          = 1'b0;
        fin             = 1'b0;
        fin_status      = swts_pkg::ST_ABSENT;
        fin_index       = '0;
        fin_count       = n_reg;
        fin_entry       = '0;

        case (state_reg)
            swts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = req.kind;
                    len_ok_next = len_ok_in;
                    tab_next    = tab_in;
                    kh_next     = req.key_high;
                    kl_next     = (req.word_length <= swts_pkg::LEN_W'(swts_pkg::SPLIT_LETTERS))
                                  ? '0 : req.key_low;
                    pos_next    = req.position;
                    n_next      = len_ok_in ? counts_reg[tab_in] : '0;
                    lo_next     = '0;
                    hi_next     = len_ok_in ? counts_reg[tab_in] : '0;
                    state_next  = swts_pkg::S_DISPATCH;
                end
            end

            swts_pkg::S_DISPATCH:
            begin
                if (!len_ok_reg)
                begin
                    fin       = 1'b1;
                    fin_count = '0;
                end
                else
                begin
                    case (kind_reg)
                        swts_pkg::KIND_LOAD:
                        begin
                            if (n_reg >= CNT_W'(swts_pkg::WORDS_PER_LENGTH))
                            begin
                                fin        = 1'b1;
                                fin_status = swts_pkg::ST_FULL;
                            end
                            else if (n_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = {tab_reg, n_m1[POS_W-1:0]};
                                state_next = swts_pkg::S_LOAD_CMP;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                cnt_we     = 1'b1;
                                fin        = 1'b1;
                                fin_status = swts_pkg::ST_OK;
                                fin_index  = n_reg;
                                fin_count  = n_reg + CNT_W'(1);
                            end
                        end
                        swts_pkg::KIND_FIND, swts_pkg::KIND_LOWER, swts_pkg::KIND_UPPER:
                        begin
                            state_next = swts_pkg::S_PROBE;
                        end
                        swts_pkg::KIND_FETCH:
                        begin
                            if ({1'b0, pos_reg} < n_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = {tab_reg, pos_reg};
                                state_next = swts_pkg::S_FETCH;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = swts_pkg::ST_BADPOS;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            swts_pkg::S_LOAD_CMP:
            begin
                fin = 1'b1;
                if (key_lt_entry)
                begin
                    fin_status = swts_pkg::ST_ORDER;
                end
                else
                begin
                    ram_we     = 1'b1;
                    cnt_we     = 1'b1;
                    fin_status = swts_pkg::ST_OK;
                    fin_index  = n_reg;
                    fin_count  = n_reg + CNT_W'(1);
                end
            end

            swts_pkg::S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = {tab_reg, mid[POS_W-1:0]};
                    mid_next   = mid;
                    state_next = swts_pkg::S_PROBE_CMP;
                end
                else
                begin
                    case (kind_reg)
                        swts_pkg::KIND_FIND:
                        begin
                            if (lo_reg < n_reg)
                            begin
                                ram_re     = 1'b1;
                                state_next = swts_pkg::S_CHECK;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        swts_pkg::KIND_LOWER:
                        begin
                            fin        = 1'b1;
                            fin_status = (lo_reg < n_reg) ? swts_pkg::ST_OK : swts_pkg::ST_ABSENT;
                            fin_index  = lo_reg;
                        end
                        swts_pkg::KIND_UPPER:
                        begin
                            fin        = 1'b1;
                            fin_status = swts_pkg::ST_OK;
                            fin_index  = lo_reg;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            swts_pkg::S_PROBE_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = swts_pkg::S_PROBE;
            end

            swts_pkg::S_CHECK:
            begin
                fin = 1'b1;
                if (ram_rdata == key)
                begin
                    fin_status = swts_pkg::ST_OK;
                    fin_index  = lo_reg;
                end
            end

            swts_pkg::S_FETCH:
            begin
                fin        = 1'b1;
                fin_status = swts_pkg::ST_OK;
                fin_index  = {1'b0, pos_reg};
                fin_entry  = ram_rdata;
            end

            swts_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = swts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = swts_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            res_status_next = fin_status;
            res_index_next  = fin_index;
            res_count_next  = fin_count;
            res_entry_next  = fin_entry;
            state_next      = swts_pkg::S_DONE;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.index       = out_index_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.entry_high  = out_entry_reg[KEY_W-1 -: swts_pkg::HIGH_W];
    assign rsp.entry_low   = out_entry_reg[swts_pkg::LOW_W-1:0];

`ifndef NO_ASSERTIONS
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swts_pkg::S_PROBE) |-> (lo_reg <= hi_reg) && (hi_reg <= n_reg))
        else $error("search window out of order");

    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swts_pkg::S_PROBE_CMP) |-> (mid_reg >= lo_reg) && (mid_reg < hi_reg))
        else $error("probe outside search window");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (n_reg < CNT_W'(swts_pkg::WORDS_PER_LENGTH)) && len_ok_reg)
        else $error("write into a full or invalid table");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp.valid && (state_reg == swts_pkg::S_IDLE))
        else $error("finished item not presented");
`endif

endmodule
